// File: src/mtfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtfd_pkg;

	// Tick and ramp timing.
	localparam logic [9:0] TICKS_PER_SECOND = 10'd1000;
	localparam logic [3:0] FADE_PERIOD      = 4'd10;
	localparam logic [7:0] FADE_STEP        = 8'd5;

	// Ceiling capture: a dim strip at mode entry gets a default ceiling.
	localparam logic [7:0] LOW_LEVEL_LIMIT  = 8'd10;
	localparam logic [7:0] DEFAULT_CEILING  = 8'd200;

	// Idle second counter saturates here.
	localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

	// Configuration register file.
	localparam int unsigned CFG_DATA_W      = 16;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd30;

	typedef enum logic {
		REG_TIMEOUT_SECONDS = 1'b0,
		REG_HOLD_BRIGHTNESS = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: src/motion_timeout_fade_dimmer.sv
`timescale 1ns / 1ps
`default_nettype none

// Motion timeout fade dimmer. Each request is one millisecond tick with the
// sensor level, the mode enable and the present strip brightness; each tick
// returns exactly one result. The block takes one request per clock and
// presents its result from an output register: the request is captured in an
// input register, the tick update runs through short counter and compare
// logic, and the result lands in the output register. A stalled result does
// not stop the next request from entering the input register, and requests
// stall only while both registers are full and the waiting result is stalled.
// Timeout and hold registers are written directly through the configuration
// port; the user writes them only while idle; the block does not enforce it.
module motion_timeout_fade_dimmer
	import mtfd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  motion_seen,
	input  wire logic                  motion_mode,
	input  wire logic [7:0]            current_level,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       level_write,
	output logic [7:0]                 new_level,
	output logic                       output_blocked,
	output logic                       presence_active
);

	// Configuration registers.
	logic [15:0] timeout_seconds_q;
	logic        hold_brightness_q;

	// Tick state.
	logic [9:0]  ms_phase_q;
	logic [15:0] idle_seconds_q;
	logic [3:0]  fade_wait_q;
	logic        presence_q;
	logic [7:0]  ceiling_q;
	logic        ceiling_captured_q;
	logic        blocked_q;

	// Input stage.
	logic        valid_s1;
	logic        motion_s1;
	logic        mode_s1;
	logic [7:0]  level_s1;

	// Output stage.
	logic        valid_s2;
	logic        write_s2;
	logic [7:0]  level_s2;
	logic        blocked_s2;
	logic        presence_s2;

	// Next-state values of one tick.
	logic [9:0]  phase_nx;
	logic [15:0] idle_nx;
	logic [3:0]  wait_nx;
	logic        presence_nx;
	logic [7:0]  ceiling_nx;
	logic        captured_nx;
	logic        blocked_nx;
	logic        write_nx;
	logic [7:0]  level_nx;
	logic [8:0]  up_sum;

	logic        advance;

	// The input stage moves on whenever the output register is free or drains.
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;

	assign out_valid       = valid_s2;
	assign level_write     = write_s2;
	assign new_level       = level_s2;
	assign output_blocked  = blocked_s2;
	assign presence_active = presence_s2;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_seconds_q <= TIMEOUT_RESET;
			hold_brightness_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TIMEOUT_SECONDS: timeout_seconds_q <= cfg_data[15:0];
				REG_HOLD_BRIGHTNESS: hold_brightness_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Tick update: counters first, then the mode logic.
	always_comb begin
		phase_nx    = ms_phase_q + 10'd1;
		idle_nx     = idle_seconds_q;
		if (phase_nx >= TICKS_PER_SECOND) begin
			phase_nx = '0;
			if (idle_seconds_q != IDLE_MAX) begin
				idle_nx = idle_seconds_q + 16'd1;
			end
		end
		wait_nx     = (fade_wait_q < FADE_PERIOD) ? fade_wait_q + 4'd1 : fade_wait_q;
		presence_nx = presence_q;
		ceiling_nx  = ceiling_q;
		captured_nx = ceiling_captured_q;
		blocked_nx  = blocked_q;
		write_nx    = 1'b0;
		level_nx    = '0;
		up_sum      = {1'b0, level_s1} + {1'b0, FADE_STEP};

		if (mode_s1) begin
			if (!ceiling_captured_q) begin
				ceiling_nx  = (level_s1 < LOW_LEVEL_LIMIT) ? DEFAULT_CEILING : level_s1;
				captured_nx = 1'b1;
			end
			if (motion_s1) begin
				presence_nx = 1'b1;
				idle_nx     = '0;
			end
			if (presence_nx && idle_nx >= timeout_seconds_q) begin
				presence_nx = 1'b0;
			end

			if (presence_nx) begin
				// Ramp up toward the ceiling.
				blocked_nx = 1'b0;
				if (wait_nx >= FADE_PERIOD && !hold_brightness_q) begin
					wait_nx = '0;
					if (level_s1 < ceiling_nx) begin
						write_nx = 1'b1;
						level_nx = (up_sum > {1'b0, ceiling_nx}) ? ceiling_nx : up_sum[7:0];
					end
				end
			end else if (wait_nx >= FADE_PERIOD) begin
				// Ramp down, and block the strip once it reaches zero.
				wait_nx = '0;
				if (level_s1 != 8'd0) begin
					write_nx = 1'b1;
					level_nx = (level_s1 > FADE_STEP) ? level_s1 - FADE_STEP : 8'd0;
				end else begin
					blocked_nx = 1'b1;
				end
			end
		end else begin
			// Mode off clears the block, the ceiling capture and the idle count, and sets presence.
			blocked_nx  = 1'b0;
			captured_nx = 1'b0;
			presence_nx = 1'b1;
			idle_nx     = '0;
		end
	end

	// Tick state advances as each request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_phase_q         <= '0;
			idle_seconds_q     <= '0;
			fade_wait_q        <= '0;
			presence_q         <= 1'b1;
			ceiling_q          <= '0;
			ceiling_captured_q <= 1'b0;
			blocked_q          <= 1'b0;
		end else if (advance) begin
			ms_phase_q         <= phase_nx;
			idle_seconds_q     <= idle_nx;
			fade_wait_q        <= wait_nx;
			presence_q         <= presence_nx;
			ceiling_q          <= ceiling_nx;
			ceiling_captured_q <= captured_nx;
			blocked_q          <= blocked_nx;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			motion_s1 <= motion_seen;
			mode_s1   <= motion_mode;
			level_s1  <= current_level;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			write_s2    <= write_nx;
			level_s2    <= level_nx;
			blocked_s2  <= blocked_nx;
			presence_s2 <= presence_nx;
		end
	end

endmodule

`default_nettype wire

// File: src/mtfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mtfd_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  motion_seen,
	input wire logic                  motion_mode,
	input wire logic [7:0]            current_level,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic                  level_write,
	input wire logic [7:0]            new_level,
	input wire logic                  output_blocked,
	input wire logic                  presence_active
);

	// No brightness is issued without the write flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !level_write |-> new_level == 8'd0)
		else $error("new_level is nonzero without level_write");

	// The strip is only blocked after presence has expired.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && output_blocked |-> !presence_active)
		else $error("output blocked while presence is active");

	// Requests are only held back when a finished result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request stalled with an empty output register");

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level_write)
			&& $stable(new_level) && $stable(output_blocked) && $stable(presence_active))
		else $error("stalled result changed");

	// A stalled request stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(motion_seen)
			&& $stable(motion_mode) && $stable(current_level))
		else $error("stalled request changed");

endmodule

bind motion_timeout_fade_dimmer mtfd_checker u_mtfd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.motion_seen     (motion_seen),
	.motion_mode     (motion_mode),
	.current_level   (current_level),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.level_write     (level_write),
	.new_level       (new_level),
	.output_blocked  (output_blocked),
	.presence_active (presence_active)
);

`default_nettype wire
